>>> rtl/ablc_pkg.sv
// Package for the accelerating button level control: types, codes, constants, helpers.
package ablc_pkg;

	localparam int LEVEL_W = 21;
	localparam int MILLI_W = 32;
	localparam int SPEED_W = 24;
	localparam int STEP_W  = 20;
	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 3;
	localparam int TICK_W  = 21;
	localparam int STEPM_W = 31;
	localparam int WIDE_W  = 34;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_SET    = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_LEVEL   = 3'd0,
		REG_MAX_LEVEL   = 3'd1,
		REG_PRESS_STEP  = 3'd2,
		REG_ACCEL_RATE  = 3'd3,
		REG_START_SPEED = 3'd4,
		REG_SPEED_LIMIT = 3'd5
	} cfg_reg_t;

	// configuration kept in the scaled form the update logic uses
	typedef struct packed {
		logic signed [MILLI_W-1:0] bottom;
		logic signed [MILLI_W-1:0] top;
		logic [STEPM_W-1:0]        step_milli;
		logic [TICK_W-1:0]         accel_tick;
		logic [SPEED_W-1:0]        start_speed;
		logic [SPEED_W-1:0]        speed_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]               cmd;
		logic                     up;
		logic                     down;
		logic signed [LEVEL_W-1:0] new_level;
	} item_t;

	localparam cfg_t CFG_RESET = '{
		bottom:      32'sd0,
		top:         32'sd1000000,
		step_milli:  31'd10000,
		accel_tick:  21'd100,
		start_speed: 24'd20000,
		speed_limit: 24'd100000
	};

	// x / 10 for 24-bit x: reciprocal 2^27/10 rounded up, exact below 2^26
	function automatic logic [TICK_W-1:0] div10(input logic [SPEED_W-1:0] x);
		logic [2*SPEED_W-1:0] prod;
		prod = {{SPEED_W{1'b0}}, x} * 48'd13421773;
		return prod[47:27];
	endfunction

	// whole units * 1000, two's complement
	function automatic logic signed [MILLI_W-1:0] to_milli(
		input logic [LEVEL_W-1:0] x);
		logic [MILLI_W-1:0] ext;
		ext = {{(MILLI_W-LEVEL_W){x[LEVEL_W-1]}}, x};
		return signed'(32'(ext * 32'd1000));
	endfunction

	// thousandths to whole units, truncated toward zero; 2^38/1000 rounded up
	function automatic logic [LEVEL_W-1:0] to_whole(input logic signed [MILLI_W-1:0] v);
		logic [MILLI_W-1:0] negv;
		logic [30:0]        mag;
		logic [59:0]        prod;
		logic [21:0]        q;
		logic [21:0]        negq;
		negv = ~v + 32'd1;
		mag  = v[MILLI_W-1] ? negv[30:0] : v[30:0];
		prod = {29'b0, mag} * 60'd274877907;
		q    = prod[59:38];
		negq = ~q + 22'd1;
		return v[MILLI_W-1] ? negq[LEVEL_W-1:0] : q[LEVEL_W-1:0];
	endfunction

endpackage

>>> rtl/ablc_update.sv
// Level, hold speed and button history registers with their combinational next-state update.
module ablc_update (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  ablc_pkg::item_t                item,
	input  ablc_pkg::cfg_t                 cfg,
	output logic signed [ablc_pkg::MILLI_W-1:0] level_next,
	output logic                           both_next
);
	import ablc_pkg::*;

	logic signed [MILLI_W-1:0] level_q;
	logic [SPEED_W-1:0]        speed_q;
	logic                      up_q;
	logic                      down_q;

	logic signed [WIDE_W-1:0]  lvl;
	logic signed [WIDE_W-1:0]  top_w;
	logic signed [WIDE_W-1:0]  bot_w;
	logic signed [WIDE_W-1:0]  step_w;
	logic signed [WIDE_W-1:0]  delta_w;
	logic [SPEED_W:0]          sp;
	logic [SPEED_W-1:0]        speed_d;
	logic                      up_d;
	logic                      down_d;

	always_comb begin
		lvl     = WIDE_W'(level_q);
		top_w   = WIDE_W'(cfg.top);
		bot_w   = WIDE_W'(cfg.bottom);
		step_w  = signed'(WIDE_W'(cfg.step_milli));
		delta_w = signed'(WIDE_W'(div10(speed_q)));
		sp      = {1'b0, speed_q} + (SPEED_W+1)'(cfg.accel_tick);
		speed_d = speed_q;
		up_d    = up_q;
		down_d  = down_q;
		unique case (item.cmd)
			CMD_SAMPLE: begin
				if (item.up && !up_q) begin
					lvl = lvl + step_w;
					if (lvl > top_w)
						lvl = top_w;
					speed_d = cfg.start_speed;
				end
				if (item.down && !down_q) begin
					lvl = lvl - step_w;
					if (lvl < bot_w)
						lvl = bot_w;
					speed_d = cfg.start_speed;
				end
				up_d   = item.up;
				down_d = item.down;
			end
			CMD_TICK: begin
				if (up_q || down_q) begin
					if (up_q)
						lvl = lvl + delta_w;
					if (down_q)
						lvl = lvl - delta_w;
					if (lvl > top_w)
						lvl = top_w;
					if (lvl < bot_w)
						lvl = bot_w;
					speed_d = (sp > {1'b0, cfg.speed_limit}) ? cfg.speed_limit
					                                         : sp[SPEED_W-1:0];
				end
			end
			CMD_SET: begin
				lvl = WIDE_W'(to_milli(item.new_level));
			end
			default: begin
			end
		endcase
	end

	assign level_next = lvl[MILLI_W-1:0];
	assign both_next  = up_d && down_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			speed_q <= '0;
			up_q    <= 1'b0;
			down_q  <= 1'b0;
		end else if (en) begin
			level_q <= level_next;
			speed_q <= speed_d;
			up_q    <= up_d;
			down_q  <= down_d;
		end
	end

endmodule

>>> rtl/accelerating_button_level_control_top.sv
// Top level of the accelerating button level control: stream ports, config registers, pipeline.
// One item is taken every cycle while results are taken. A result passes through an input
// register, the combinational state update into the second stage, and the thousandths-to-units
// conversion (a constant reciprocal multiply) into the output register. Every item gives
// exactly one result. Configuration writes land in the next cycle and are held in scaled form.
module accelerating_button_level_control_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // up_held[0], down_held[1], new_level[22:2], zero[23]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // level[20:0], both_held[21], zero[23:22]
	input  logic        cfg_we,
	input  logic [ablc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ablc_pkg::CFG_W-1:0]     cfg_data
);
	import ablc_pkg::*;

	cfg_t  cfg_q;
	item_t item_s1;
	logic  valid_s1;
	logic  valid_s2;
	logic signed [MILLI_W-1:0] level_s2;
	logic  both_s2;
	logic  out_valid_q;
	logic [23:0] out_data_q;

	logic adv1;
	logic adv2;
	logic signed [MILLI_W-1:0] level_next;
	logic both_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_LEVEL:   cfg_q.bottom      <= to_milli(cfg_data[LEVEL_W-1:0]);
				REG_MAX_LEVEL:   cfg_q.top         <= to_milli(cfg_data[LEVEL_W-1:0]);
				REG_PRESS_STEP:  cfg_q.step_milli  <= STEPM_W'({11'b0, cfg_data[STEP_W-1:0]}
				                                      * 31'd1000);
				REG_ACCEL_RATE:  cfg_q.accel_tick  <= div10(cfg_data);
				REG_START_SPEED: cfg_q.start_speed <= cfg_data;
				REG_SPEED_LIMIT: cfg_q.speed_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign adv2     = !out_valid_q || m_tready;
	assign adv1     = !valid_s2 || adv2;
	assign s_tready = !valid_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (adv1)
				valid_s1 <= 1'b0;
			if (adv1)
				valid_s2 <= valid_s1;
			if (adv2)
				out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd       <= s_tuser;
			item_s1.up        <= s_tdata[0];
			item_s1.down      <= s_tdata[1];
			item_s1.new_level <= s_tdata[22:2];
		end
		if (adv1 && valid_s1) begin
			level_s2 <= level_next;
			both_s2  <= both_next;
		end
		if (adv2 && valid_s2)
			out_data_q <= {2'b00, both_s2, to_whole(level_s2)};
	end

	ablc_update u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv1 && valid_s1),
		.item       (item_s1),
		.cfg        (cfg_q),
		.level_next (level_next),
		.both_next  (both_next)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

>>> rtl/ablc_checker.sv
// Port-level checks for the accelerating button level control, bound to the top level.
module ablc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	import ablc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled with output draining");

	a_set_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == CMD_SET) ##1 m_tready ##1 m_tready
		|=> m_tvalid && m_tdata[20:0] == $past(s_tdata[22:2], 3))
		else $error("set level not returned");

	a_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid && s_tready)
		else $error("pipeline not empty after reset");

endmodule

bind accelerating_button_level_control_top ablc_checker u_ablc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/tb.sv
// Testbench for the accelerating button level control: stream stimulus, prediction, checking.
`timescale 1ns / 1ps

module tb;
	import ablc_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD = 48;
	localparam int PRINT_CAP = 40;

	typedef struct {
		logic signed [LEVEL_W-1:0] level;
		logic                      both;
	} level_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	accelerating_button_level_control_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// predictor copy of configuration and state
	logic signed [LEVEL_W-1:0] min_lvl = 21'sd0;
	logic signed [LEVEL_W-1:0] max_lvl = 21'sd1000;
	logic [STEP_W-1:0]         step_units = 20'd10;
	logic [SPEED_W-1:0]        accel = 24'd1000;
	logic [SPEED_W-1:0]        start_spd = 24'd20000;
	logic [SPEED_W-1:0]        spd_limit = 24'd100000;
	longint                    level_milli = 0;
	logic [SPEED_W-1:0]        hold_speed = '0;
	logic                      up_was = 1'b0;
	logic                      down_was = 1'b0;

	item_t         button_q[$];
	level_result_t level_q[$];
	item_t         s_item = '0;
	logic          s_fire = 1'b0;
	int            s_gap = 0;
	int            m_gap = 0;
	int            hold_left = 0;
	logic          hold_req = 1'b0;
	logic          hold_done = 1'b0;
	logic          quiet = 1'b0;
	int            n_queued = 0;
	int            n_accepted = 0;
	int            mismatches = 0;
	int            stall_cycles = 0;

	task automatic report(string msg);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void update_level(item_t it);
		longint top, bottom, delta, sp;
		level_result_t r;
		top = longint'(max_lvl) * 1000;
		bottom = longint'(min_lvl) * 1000;
		case (it.cmd)
			CMD_SAMPLE: begin
				if (it.up && !up_was) begin
					level_milli += longint'(step_units) * 1000;
					if (level_milli > top)
						level_milli = top;
					hold_speed = start_spd;
				end
				up_was = it.up;
				if (it.down && !down_was) begin
					level_milli -= longint'(step_units) * 1000;
					if (level_milli < bottom)
						level_milli = bottom;
					hold_speed = start_spd;
				end
				down_was = it.down;
			end
			CMD_TICK: begin
				if (up_was || down_was) begin
					delta = longint'(hold_speed / 10);
					if (up_was)
						level_milli += delta;
					if (down_was)
						level_milli -= delta;
					if (level_milli > top)
						level_milli = top;
					if (level_milli < bottom)
						level_milli = bottom;
					sp = longint'(hold_speed) + longint'(accel / 10);
					if (sp > longint'(spd_limit))
						sp = longint'(spd_limit);
					hold_speed = sp[SPEED_W-1:0];
				end
			end
			CMD_SET: level_milli = longint'(it.new_level) * 1000;
			default: ;
		endcase
		r.level = LEVEL_W'(level_milli / 1000);
		r.both = up_was && down_was;
		level_q.push_back(r);
	endfunction

	task automatic queue_item(logic [1:0] cmd, int up, int down, int lvl);
		item_t it;
		it.cmd = cmd;
		it.up = up[0];
		it.down = down[0];
		it.new_level = LEVEL_W'(lvl);
		button_q.push_back(it);
		n_queued++;
	endtask

	task automatic queue_random(int count);
		int r, lvl;
		repeat (count) begin
			r = $urandom_range(0, 99);
			lvl = $urandom;
			if (r < 35)
				queue_item(CMD_SAMPLE, $urandom_range(0, 4) < 3, $urandom_range(0, 4) < 2, lvl);
			else if (r < 85)
				queue_item(CMD_TICK, $urandom, $urandom, lvl);
			else if (r < 97) begin
				if ($urandom_range(0, 1))
					lvl = int'($urandom_range(0, 2000000)) - 1000000;
				else
					lvl = int'($urandom_range(0, 12000)) - 6000;
				queue_item(CMD_SET, $urandom, $urandom, lvl);
			end else
				queue_item(CMD_UNUSED, $urandom, $urandom, lvl);
		end
	endtask

	task automatic put_reg(cfg_reg_t idx, int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		case (idx)
			REG_MIN_LEVEL:   min_lvl = LEVEL_W'(val);
			REG_MAX_LEVEL:   max_lvl = LEVEL_W'(val);
			REG_PRESS_STEP:  step_units = STEP_W'(val);
			REG_ACCEL_RATE:  accel = SPEED_W'(val);
			REG_START_SPEED: start_spd = SPEED_W'(val);
			REG_SPEED_LIMIT: spd_limit = SPEED_W'(val);
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_config(int lo, int hi, int step, int acc, int start, int lim);
		put_reg(REG_MIN_LEVEL, lo);
		put_reg(REG_MAX_LEVEL, hi);
		put_reg(REG_PRESS_STEP, step);
		put_reg(REG_ACCEL_RATE, acc);
		put_reg(REG_START_SPEED, start);
		put_reg(REG_SPEED_LIMIT, lim);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_random_config();
		load_config(int'($urandom_range(0, 10000)) - 5000, int'($urandom_range(0, 10000)) - 5000,
			$urandom_range(0, 50), $urandom_range(0, 100000), $urandom_range(0, 100000),
			$urandom_range(0, 200000));
	endtask

	task automatic drain();
		while (n_accepted != n_queued || level_q.size() != 0)
			@(posedge clk);
		repeat (6) @(negedge clk);
	endtask

	// sender
	always @(negedge clk) begin
		logic  v;
		item_t d;
		int    gap;
		v = s_tvalid;
		d = s_item;
		gap = s_gap;
		if (arst_n && (!s_tvalid || s_fire)) begin
			v = 1'b0;
			if (gap > 0)
				gap--;
			else if (button_q.size() > 0) begin
				if (!quiet && $urandom_range(0, 5) == 0)
					gap = $urandom_range(1, 3) - 1;
				else begin
					d = button_q.pop_front();
					v = 1'b1;
				end
			end
		end
		s_tvalid <= v;
		s_item <= d;
		s_tdata <= {1'b0, d.new_level, d.down, d.up};
		s_tuser <= d.cmd;
		s_gap <= gap;
	end

	// receiver, with one long hold-off on request
	always @(negedge clk) begin
		logic rdy;
		int   gap, hl;
		rdy = 1'b1;
		gap = m_gap;
		hl = hold_left;
		if (!arst_n)
			rdy = 1'b0;
		else if (hl > 0) begin
			hl--;
			rdy = 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hl = LONG_HOLD;
			rdy = 1'b0;
		end else if (gap > 0) begin
			gap--;
			rdy = 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3) - 1;
			rdy = 1'b0;
		end
		m_tready <= rdy;
		m_gap <= gap;
		hold_left <= hl;
	end

	// monitor: check results, predict on input transfers
	always @(posedge clk) begin
		level_result_t e;
		logic signed [LEVEL_W-1:0] got;
		s_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[LEVEL_W-1:0];
				if (level_q.size() == 0)
					report($sformatf("unexpected result level %0d", got));
				else begin
					e = level_q.pop_front();
					if (got !== e.level)
						report($sformatf("level got %0d want %0d", got, e.level));
					if (m_tdata[21] !== e.both)
						report($sformatf("both_held got %b want %b", m_tdata[21], e.both));
				end
			end
			if (s_tvalid && s_tready) begin
				update_level(s_item);
				n_accepted++;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset configuration
		queue_item(CMD_SET, 0, 0, 500);
		queue_item(CMD_SAMPLE, 1, 0, 0);
		queue_item(CMD_TICK, 0, 0, 0);
		queue_item(CMD_TICK, 0, 0, 0);
		queue_item(CMD_TICK, 0, 0, 0);
		queue_item(CMD_SAMPLE, 0, 0, 0);
		queue_item(CMD_TICK, 1, 1, -1);
		queue_item(CMD_SAMPLE, 0, 1, 0);
		queue_item(CMD_TICK, 0, 0, 0);
		queue_item(CMD_TICK, 0, 0, 0);
		queue_item(CMD_SAMPLE, 1, 1, 0);
		queue_item(CMD_SAMPLE, 0, 0, 0);
		queue_item(CMD_SAMPLE, 1, 1, 0);
		queue_item(CMD_TICK, 0, 0, 0);
		queue_item(CMD_SAMPLE, 0, 0, 0);
		queue_item(CMD_SET, 0, 0, 1000000);
		queue_item(CMD_SET, 0, 0, -1000000);
		queue_item(CMD_SAMPLE, 0, 1, 0);
		queue_item(CMD_SET, 0, 0, 999);
		queue_item(CMD_SAMPLE, 1, 0, 0);
		queue_item(CMD_UNUSED, 1, 1, -1048576);
		queue_item(CMD_SET, 1, 1, -1);
		queue_item(CMD_SAMPLE, 0, 0, 0);
		drain();
		queue_random(100);
		drain();

		// widest bounds and fastest speeds, with a long receiver hold-off
		load_config(-1000000, 1000000, 1000000, 10000000, 10000000, 10000000);
		queue_random(90);
		hold_req <= 1'b1;
		drain();

		// crossed bounds, everything else at zero
		load_config(1000000, -1000000, 0, 0, 0, 0);
		queue_random(80);
		drain();

		repeat (3) begin
			load_random_config();
			queue_random(60);
			drain();
		end

		quiet <= 1'b1;
		load_random_config();
		queue_random(100);
		drain();
		repeat (10) @(posedge clk);

		if (level_q.size() != 0)
			report($sformatf("%0d results never arrived", level_q.size()));
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
